FILE: hw/rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU pipeline.
// No dependencies; every RTL file refers to this package by scoped names.
`default_nettype none
package fpa_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 8;
  // Divider numerator width: magnitude shifted left by the fraction bits
  localparam int unsigned NumBits  = WordBits + FracBits;
  localparam int unsigned MagBits  = 2 * WordBits + 1;

  typedef enum logic [3:0] {
    OpAdd   = 4'd0,
    OpSub   = 4'd1,
    OpMul   = 4'd2,
    OpDiv   = 4'd3,
    OpInc   = 4'd4,
    OpDec   = 4'd5,
    OpGt    = 4'd6,
    OpLt    = 4'd7,
    OpGe    = 4'd8,
    OpLe    = 4'd9,
    OpEq    = 4'd10,
    OpNe    = 4'd11,
    OpMin   = 4'd12,
    OpMax   = 4'd13,
    OpToInt = 4'd14,
    OpNone  = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ErrOk       = 2'd0,
    ErrOverflow = 2'd1,
    ErrDivZero  = 2'd2,
    ErrRsvd     = 2'd3
  } err_e;

  localparam logic [WordBits-1:0] MaxPos = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] MinNeg = {1'b1, {(WordBits-1){1'b0}}};

  typedef struct packed {
    logic [3:0]                 kind;
    logic signed [WordBits-1:0] operand_a;
    logic signed [WordBits-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WordBits-1:0] value;
    logic                       flag;
    logic [1:0]                 error_code;
  } rsp_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    op_e                 op;
    logic                neg;
    logic [WordBits-1:0] value;
    logic                flag;
    err_e                err;
    logic [WordBits-1:0] ma;
    logic [WordBits-1:0] mb;
  } ctl_t;

  // Divider working set, one quotient bit per stage
  typedef struct packed {
    logic [WordBits-1:0] rem;
    logic [NumBits-1:0]  quo;
    logic [NumBits-1:0]  num;
  } div_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fpa_front.sv
// Front stage: decode, short operations, operand magnitudes, divider setup.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire fpa_pkg::req_t req_i,
  output logic               valid_o,
  output fpa_pkg::ctl_t      ctl_o,
  output fpa_pkg::div_t      div_o
);

  localparam int unsigned W = fpa_pkg::WordBits;
  localparam int unsigned F = fpa_pkg::FracBits;

  logic                valid_q;
  fpa_pkg::ctl_t       ctl_d, ctl_q;
  fpa_pkg::div_t       div_d, div_q;
  logic signed [W-1:0] a, b;
  logic [W-1:0]        sum, dif;
  logic                a_lt_b, b_lt_a;

  assign a = req_i.operand_a;
  assign b = req_i.operand_b;
  assign sum = a + b;
  assign dif = a - b;
  assign a_lt_b = a < b;
  assign b_lt_a = b < a;

  // Evaluate the short operations and set up the long ones
  always_comb begin
    ctl_d       = '0;
    ctl_d.op    = fpa_pkg::op_e'(req_i.kind);
    ctl_d.err   = fpa_pkg::ErrOk;
    ctl_d.neg   = a[W-1] ^ b[W-1];
    ctl_d.ma    = a[W-1] ? W'(-a) : W'(a);
    ctl_d.mb    = b[W-1] ? W'(-b) : W'(b);
    case (fpa_pkg::op_e'(req_i.kind))
      fpa_pkg::OpAdd: begin
        ctl_d.value = sum;
        if (a[W-1] == b[W-1] && sum[W-1] != a[W-1]) begin
          ctl_d.value = a[W-1] ? fpa_pkg::MinNeg : fpa_pkg::MaxPos;
          ctl_d.err   = fpa_pkg::ErrOverflow;
        end
      end
      fpa_pkg::OpSub: begin
        ctl_d.value = dif;
        if (a[W-1] != b[W-1] && dif[W-1] != a[W-1]) begin
          ctl_d.value = a[W-1] ? fpa_pkg::MinNeg : fpa_pkg::MaxPos;
          ctl_d.err   = fpa_pkg::ErrOverflow;
        end
      end
      fpa_pkg::OpInc: begin
        if (a == fpa_pkg::MaxPos) begin
          ctl_d.value = fpa_pkg::MaxPos;
          ctl_d.err   = fpa_pkg::ErrOverflow;
        end else begin
          ctl_d.value = W'(a + 1'b1);
        end
      end
      fpa_pkg::OpDec: begin
        if (a == fpa_pkg::MinNeg) begin
          ctl_d.value = fpa_pkg::MinNeg;
          ctl_d.err   = fpa_pkg::ErrOverflow;
        end else begin
          ctl_d.value = W'(a - 1'b1);
        end
      end
      fpa_pkg::OpGt:    ctl_d.flag  = b_lt_a;
      fpa_pkg::OpLt:    ctl_d.flag  = a_lt_b;
      fpa_pkg::OpGe:    ctl_d.flag  = !a_lt_b;
      fpa_pkg::OpLe:    ctl_d.flag  = !b_lt_a;
      fpa_pkg::OpEq:    ctl_d.flag  = (a == b);
      fpa_pkg::OpNe:    ctl_d.flag  = (a != b);
      fpa_pkg::OpMin:   ctl_d.value = a_lt_b ? a : b;
      fpa_pkg::OpMax:   ctl_d.value = b_lt_a ? a : b;
      fpa_pkg::OpToInt: ctl_d.value = W'(a >>> F);
      default:          ctl_d.value = '0;
    endcase
  end

  // Load the divider with the shifted dividend magnitude
  always_comb begin
    div_d     = '0;
    div_d.num = {ctl_d.ma, {F{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_d;
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fpa_div_stage.sv
// One restoring-divider stage: retires one quotient bit per cycle.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire fpa_pkg::ctl_t ctl_i,
  input  wire fpa_pkg::div_t div_i,
  output logic               valid_o,
  output fpa_pkg::ctl_t      ctl_o,
  output fpa_pkg::div_t      div_o
);

  localparam int unsigned W = fpa_pkg::WordBits;
  localparam int unsigned N = fpa_pkg::NumBits;

  logic          valid_q;
  fpa_pkg::ctl_t ctl_q;
  fpa_pkg::div_t div_d, div_q;
  logic [W:0]    trial;
  logic          ge;

  // Shift in the next dividend bit and subtract when the divisor fits
  assign trial = {div_i.rem, div_i.num[N-1]};
  assign ge    = trial >= {1'b0, ctl_i.mb};

  always_comb begin
    div_d.rem = ge ? W'(trial - {1'b0, ctl_i.mb}) : W'(trial);
    div_d.quo = {div_i.quo[N-2:0], ge};
    div_d.num = {div_i.num[N-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q <= ctl_i;
    div_q <= div_d;
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign div_o   = div_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fpa_back.sv
// Back end: magnitude multiply, then rounding, sign and saturation of mul/div.
// Depends on fpa_pkg.
`default_nettype none
module fpa_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire fpa_pkg::ctl_t ctl_i,
  input  wire fpa_pkg::div_t div_i,
  output logic               valid_o,
  output fpa_pkg::rsp_t      rsp_o
);

  localparam int unsigned W = fpa_pkg::WordBits;
  localparam int unsigned F = fpa_pkg::FracBits;
  localparam int unsigned N = fpa_pkg::NumBits;
  localparam int unsigned M = fpa_pkg::MagBits;

  logic            mul_valid_q, out_valid_q;
  fpa_pkg::ctl_t   ctl_q;
  logic [N-1:0]    quo_q;
  logic            rnd_q;
  logic [2*W-1:0]  prod_q;
  fpa_pkg::rsp_t   rsp_d, rsp_q;
  logic [M-1:0]    rounded, mag;
  logic [M-1:0]    limit;

  assign limit = M'({1'b1, {(W-1){1'b0}}});

  // Stage A: multiply magnitudes, settle the divider rounding bit
  always_ff @(posedge clk_i) begin
    ctl_q  <= ctl_i;
    quo_q  <= div_i.quo;
    rnd_q  <= {div_i.rem, 1'b0} >= {1'b0, ctl_i.mb};
    prod_q <= ctl_i.ma * ctl_i.mb;
  end

  // Stage B: round, apply sign, saturate
  assign rounded = M'({1'b0, prod_q}) + M'({1'b1, {(F-1){1'b0}}});

  always_comb begin
    mag = '0;
    if (ctl_q.op == fpa_pkg::OpMul) begin
      mag = rounded >> F;
    end else begin
      mag = M'(quo_q) + M'(rnd_q);
    end
  end

  always_comb begin
    rsp_d.value      = ctl_q.value;
    rsp_d.flag       = ctl_q.flag;
    rsp_d.error_code = ctl_q.err;
    if (ctl_q.op == fpa_pkg::OpMul || ctl_q.op == fpa_pkg::OpDiv) begin
      rsp_d.error_code = fpa_pkg::ErrOk;
      if (ctl_q.op == fpa_pkg::OpDiv && ctl_q.mb == '0) begin
        rsp_d.value      = '0;
        rsp_d.error_code = fpa_pkg::ErrDivZero;
      end else if (ctl_q.neg) begin
        if (mag > limit) begin
          rsp_d.value      = fpa_pkg::MinNeg;
          rsp_d.error_code = fpa_pkg::ErrOverflow;
        end else begin
          rsp_d.value = W'(-mag[W-1:0]);
        end
      end else begin
        if (mag >= limit) begin
          rsp_d.value      = fpa_pkg::MaxPos;
          rsp_d.error_code = fpa_pkg::ErrOverflow;
        end else begin
          rsp_d.value = mag[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      out_valid_q <= mul_valid_q;
    end
  end

  assign valid_o = out_valid_q;
  assign rsp_o   = rsp_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_point_q24_8_alu_top.sv
// Channel   | Signals                  | Direction | Handshake
// request   | start_i, req_i, busy_o   | in        | taken when start_i && !busy_o
// result    | valid_o, rsp_o           | out       | one-cycle strobe, no back-pressure
//
// One request enters per cycle; busy_o stays low.
// A request passes through the front stage, one divider stage per quotient bit,
// the multiply stage and the round/saturate stage. The divider chain sets the depth.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline always advances.
// Depends on fpa_pkg, fpa_front, fpa_div_stage and fpa_back.
`default_nettype none
module fixed_point_q24_8_alu_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire fpa_pkg::req_t req_i,
  output logic               busy_o,
  output logic               valid_o,
  output fpa_pkg::rsp_t      rsp_o
);

  localparam int unsigned N = fpa_pkg::NumBits;

  logic          stg_valid [N+1];
  fpa_pkg::ctl_t stg_ctl   [N+1];
  fpa_pkg::div_t stg_div   [N+1];

  assign busy_o = 1'b0;

  // Decode and short operations
  fpa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (req_i),
    .valid_o (stg_valid[0]),
    .ctl_o   (stg_ctl[0]),
    .div_o   (stg_div[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar i = 0; i < N; i++) begin : g_div
    fpa_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[i]),
      .ctl_i   (stg_ctl[i]),
      .div_i   (stg_div[i]),
      .valid_o (stg_valid[i+1]),
      .ctl_o   (stg_ctl[i+1]),
      .div_o   (stg_div[i+1])
    );
  end

  // Multiply, round and saturate
  fpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[N]),
    .ctl_i   (stg_ctl[N]),
    .div_i   (stg_div[N]),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

`ifndef SYNTH
  // A comparison flag never comes with an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.flag |-> rsp_o.error_code == fpa_pkg::ErrOk)
    else $error("flag raised together with an error code");

  // Divide by zero always returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.error_code == fpa_pkg::ErrDivZero |-> rsp_o.value == '0)
    else $error("divide by zero with nonzero value");

  // A result leaving the divider chain reaches valid_o through the multiply and round/saturate stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid[N] |=> ##1 valid_o)
    else $error("result lost between divider and output");
`endif

endmodule
`default_nettype wire
